[sv/mbac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbac_pkg
// Types and constants shared by the coil frame receiver: transfer payloads,
// event codes, parity selectors and frame layout.
// ----------------------------------------------------------------------------
package mbac_pkg;

	// line event codes
	localparam logic [1:0] MODE_CHAR     = 2'd0;
	localparam logic [1:0] MODE_FRAMING  = 2'd1;
	localparam logic [1:0] MODE_OVERRUN  = 2'd2;
	localparam logic [1:0] MODE_TIMEOUT  = 2'd3;

	// parity selector
	localparam logic [1:0] PAR_SEL_NONE  = 2'd0;
	localparam logic [1:0] PAR_SEL_EVEN  = 2'd1;
	localparam logic [1:0] PAR_SEL_ODD   = 2'd2;

	// frame event codes
	localparam logic [1:0] EV_NONE       = 2'd0;
	localparam logic [1:0] EV_APPLIED    = 2'd1;
	localparam logic [1:0] EV_DISCARDED  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_PARITY    = 2'd0;
	localparam logic [1:0] REG_STATION   = 2'd1;
	localparam logic [1:0] REG_COIL_ADDR = 2'd2;

	localparam int CFG_DATA_W            = 16;

	// reset values of the configuration registers
	localparam logic [1:0]  PARITY_RESET    = PAR_SEL_EVEN;
	localparam logic [7:0]  STATION_RESET   = 8'h00;
	localparam logic [15:0] COIL_ADDR_RESET = 16'd1000;

	// frame layout
	localparam int FRAME_CHAR_LIMIT_DEF  = 80;
	localparam int FRAME_LEN             = 20;
	localparam logic [7:0] FUNC_WRITE_COILS = 8'h0F;
	localparam logic [7:0] QTY_HI        = 8'h00;
	localparam logic [7:0] QTY_LO        = 8'h10;
	localparam logic [7:0] BYTE_COUNT    = 8'h02;

	// byte positions within the frame
	localparam logic [3:0] IDX_STATION   = 4'd0;
	localparam logic [3:0] IDX_FUNC      = 4'd1;
	localparam logic [3:0] IDX_ADDR_HI   = 4'd2;
	localparam logic [3:0] IDX_ADDR_LO   = 4'd3;
	localparam logic [3:0] IDX_QTY_HI    = 4'd4;
	localparam logic [3:0] IDX_QTY_LO    = 4'd5;
	localparam logic [3:0] IDX_COUNT     = 4'd6;
	localparam logic [3:0] IDX_DATA_LO   = 4'd7;

	// ASCII characters
	localparam logic [6:0] CH_COLON      = 7'h3A;
	localparam logic [6:0] CH_CR         = 7'h0D;
	localparam logic [6:0] CH_LF         = 7'h0A;
	localparam logic [6:0] CH_0          = 7'h30;
	localparam logic [6:0] CH_9          = 7'h39;
	localparam logic [6:0] CH_A          = 7'h41;
	localparam logic [6:0] CH_F          = 7'h46;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] coil_outputs;
		logic       red_led_on;
		logic       yellow_led_on;
		logic [1:0] frame_event;
	} result_t;

endpackage

[sv/modbus_ascii_coil_frame_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_ascii_coil_frame_receiver
// Receives UART events, checks parity, decodes an addressed Write Multiple
// Coils frame with LRC and drives the low data byte to the coil outputs.
// ----------------------------------------------------------------------------
// One UART event enters per clock cycle while item_stall is low and yields
// exactly one result. An accepted event is held in the input register,
// where the frame decoder updates the receiver state and loads the result
// register; the result register then offers the result until the output
// side takes it. The input register frees itself whenever the result
// register is empty or being taken, so one new event can be held while a
// finished result still waits. Configuration writes take effect at the
// next clock edge; the user must make them only while the block is idle,
// and the block itself does not enforce this.
module modbus_ascii_coil_frame_receiver
	import mbac_pkg::*;
#(
	parameter int FRAME_CHAR_LIMIT = FRAME_CHAR_LIMIT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result
);

	localparam int CW = $clog2(FRAME_CHAR_LIMIT + 1);
	localparam logic [CW-1:0] LIMIT_C = CW'(FRAME_CHAR_LIMIT);
	localparam logic [CW-1:0] LEN_C   = CW'(FRAME_LEN);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_RECV    = 2'd1;
	localparam logic [1:0] PH_WAIT_LF = 2'd2;

	// configuration
	logic [1:0]  parity_mode_q;
	logic [7:0]  station_q;
	logic [15:0] coil_addr_q;

	// input stage
	logic  valid_s1;
	item_t item_s1;
	logic  advance;

	// receiver state
	logic [1:0]    phase_q, phase_d;
	logic          good_q, good_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [3:0]    nib_hi_q, nib_hi_d;
	logic          hex_bad_q, hex_bad_d;
	logic [7:0]    lrc_q, lrc_d;
	logic          hdr_ok_q, hdr_ok_d;
	logic [7:0]    data_q, data_d;
	logic [7:0]    coil_q, coil_d;
	logic          red_q, red_d;
	logic          yellow_q, yellow_d;
	logic [1:0]    event_d;

	// decode helpers
	logic       parity_ok;
	logic [6:0] ch;
	logic       is_digit, is_upper, is_hex;
	logic [3:0] nib;
	logic [7:0] byte_val;
	logic [7:0] want;
	logic [3:0] byte_idx;
	logic       frame_pass;

	logic    out_valid_q;
	result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_mode_q <= PARITY_RESET;
			station_q     <= STATION_RESET;
			coil_addr_q   <= COIL_ADDR_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PARITY:    parity_mode_q <= cfg_data[1:0];
				REG_STATION:   station_q     <= cfg_data[7:0];
				REG_COIL_ADDR: coil_addr_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign advance    = valid_s1 && (!out_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		case (parity_mode_q)
			PAR_SEL_EVEN: parity_ok = ~^item_s1.rx_byte;
			PAR_SEL_ODD:  parity_ok = ^item_s1.rx_byte;
			default:      parity_ok = 1'b1;
		endcase
	end

	assign ch       = item_s1.rx_byte[6:0];
	assign is_digit = (ch >= CH_0) && (ch <= CH_9);
	assign is_upper = (ch >= CH_A) && (ch <= CH_F);
	assign is_hex   = is_digit || is_upper;
	assign nib      = is_digit ? ch[3:0] : (is_upper ? 4'(ch - CH_A + 7'd10) : 4'd0);
	assign byte_val = {nib_hi_q, nib};
	assign byte_idx = cnt_q[4:1];

	always_comb begin
		case (byte_idx)
			IDX_STATION: want = station_q;
			IDX_FUNC:    want = FUNC_WRITE_COILS;
			IDX_ADDR_HI: want = coil_addr_q[15:8];
			IDX_ADDR_LO: want = coil_addr_q[7:0];
			IDX_QTY_HI:  want = QTY_HI;
			IDX_QTY_LO:  want = QTY_LO;
			IDX_COUNT:   want = BYTE_COUNT;
			default:     want = byte_val;
		endcase
	end

	assign frame_pass = good_q && (cnt_q == LEN_C) && !hex_bad_q && (lrc_q == 8'h00) && hdr_ok_q;

	always_comb begin
		phase_d   = phase_q;
		good_d    = good_q;
		cnt_d     = cnt_q;
		nib_hi_d  = nib_hi_q;
		hex_bad_d = hex_bad_q;
		lrc_d     = lrc_q;
		hdr_ok_d  = hdr_ok_q;
		data_d    = data_q;
		coil_d    = coil_q;
		red_d     = red_q;
		yellow_d  = yellow_q;
		event_d   = EV_NONE;
		if (item_s1.mode != MODE_CHAR || !parity_ok) begin
			good_d = 1'b0;
			red_d  = 1'b1;
		end else if (ch == CH_COLON) begin
			good_d    = 1'b1;
			cnt_d     = '0;
			nib_hi_d  = 4'd0;
			hex_bad_d = 1'b0;
			lrc_d     = 8'h00;
			hdr_ok_d  = 1'b1;
			data_d    = 8'h00;
			yellow_d  = 1'b1;
			red_d     = 1'b0;
			phase_d   = PH_RECV;
		end else if (phase_q == PH_RECV) begin
			if (ch == CH_CR) begin
				phase_d = PH_WAIT_LF;
			end else if (cnt_q >= LIMIT_C) begin
				// drop characters past the limit
				good_d = 1'b0;
				red_d  = 1'b1;
			end else begin
				if (cnt_q < LEN_C) begin
					if (!is_hex) begin
						hex_bad_d = 1'b1;
					end
					if (!cnt_q[0]) begin
						nib_hi_d = nib;
					end else begin
						lrc_d = lrc_q + byte_val;
						if (byte_idx == IDX_DATA_LO) begin
							data_d = byte_val;
						end
						if (byte_val != want) begin
							hdr_ok_d = 1'b0;
						end
					end
				end
				cnt_d = cnt_q + 1'b1;
			end
		end else if (phase_q == PH_WAIT_LF) begin
			if (ch == CH_LF) begin
				yellow_d = 1'b0;
				phase_d  = PH_IDLE;
				if (frame_pass) begin
					coil_d  = data_q;
					event_d = EV_APPLIED;
				end else begin
					red_d   = 1'b1;
					event_d = EV_DISCARDED;
				end
			end else begin
				good_d = 1'b0;
			end
		end else begin
			phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			good_q    <= 1'b0;
			cnt_q     <= '0;
			nib_hi_q  <= 4'd0;
			hex_bad_q <= 1'b0;
			lrc_q     <= 8'h00;
			hdr_ok_q  <= 1'b1;
			data_q    <= 8'h00;
			coil_q    <= 8'h00;
			red_q     <= 1'b0;
			yellow_q  <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_d;
			good_q    <= good_d;
			cnt_q     <= cnt_d;
			nib_hi_q  <= nib_hi_d;
			hex_bad_q <= hex_bad_d;
			lrc_q     <= lrc_d;
			hdr_ok_q  <= hdr_ok_d;
			data_q    <= data_d;
			coil_q    <= coil_d;
			red_q     <= red_d;
			yellow_q  <= yellow_d;
		end
	end

	// result register: load on advance, drop once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.coil_outputs  <= coil_d;
			out_q.red_led_on    <= red_d;
			out_q.yellow_led_on <= yellow_d;
			out_q.frame_event   <= event_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef ASSERT_OFF
	a_yellow_tracks_phase: assert property (@(posedge clk) disable iff (!arst_n)
		yellow_q == (phase_q != PH_IDLE))
		else $error("yellow LED out of step with frame phase");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LIMIT_C)
		else $error("character count past limit");

	a_applied_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_event == EV_APPLIED |->
			!result.red_led_on && !result.yellow_led_on)
		else $error("applied frame with error or busy indicator");

	a_event_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		advance && event_d != EV_NONE |=> phase_q == PH_IDLE)
		else $error("frame event without return to idle");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with free stages");
`endif

endmodule
